// ----- src/ssdc_pkg.sv -----
// Shared types and constants for the seven-segment display controller.
// Depends on nothing; every other file but ssdc_checker imports it.
`timescale 1ns / 1ps

package ssdc_pkg;

    // Command codes carried in the slave-side tuser field.
    localparam logic [1:0] CMD_NUMBER = 2'd0;
    localparam logic [1:0] CMD_SCAN   = 2'd1;
    localparam logic [1:0] CMD_BLANK  = 2'd2;
    localparam logic [1:0] CMD_COLON  = 2'd3;

    // Field widths of one request.
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned FIRST_W = 2;
    localparam int unsigned END_W   = 3;
    localparam int unsigned VALUE_W = 14;
    localparam int unsigned POINT_W = 3;

    // A 14-bit value has at most five decimal digits.
    localparam int unsigned NUM_DIGITS = 5;

    // Segment pattern with the decimal point in bit 7.
    localparam logic [7:0] POINT_BIT = 8'h80;

    // One request as it travels down the pipeline, without the value.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIRST_W-1:0] first_pos;
        logic [END_W-1:0]   end_pos;
        logic [POINT_W-1:0] point_pos;
        logic               fill_zero;
        logic               colon_on;
    } ssdc_req_t;

    // Decimal form of a number write, plus its validity.
    typedef struct packed {
        logic                       ok;
        logic [NUM_DIGITS-1:1]      big;
        logic [NUM_DIGITS-1:0][3:0] digit;
    } ssdc_num_t;

    // One result as the execute stage produces it.
    typedef struct packed {
        logic [3:0] digit_select;
        logic [7:0] segments_n;
        logic       colon_out;
        logic       rejected;
    } ssdc_res_t;

endpackage

// ----- src/ssdc_split.sv -----
// Checks a number write and splits its value into decimal digits over three stages.
// Depends on ssdc_pkg; holds no display state, so it can run ahead of the execute stage.
`timescale 1ns / 1ps

module ssdc_split #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  ssdc_pkg::ssdc_req_t         in_req,
    input  logic [ssdc_pkg::VALUE_W-1:0] in_value,
    output logic                        out_valid,
    output ssdc_pkg::ssdc_req_t         out_req,
    output ssdc_pkg::ssdc_num_t         out_num
);
    import ssdc_pkg::*;

    localparam logic [3:0] DIGIT_COUNT_4 = 4'(DIGIT_COUNT);

    // Powers of ten up to the largest one a 14-bit value can reach.
    function automatic logic [VALUE_W-1:0] pow10(input logic [2:0] n);
        logic [VALUE_W-1:0] p;
        begin
            unique case (n)
                3'd0:    p = 14'd1;
                3'd1:    p = 14'd10;
                3'd2:    p = 14'd100;
                3'd3:    p = 14'd1000;
                3'd4:    p = 14'd10000;
                default: p = 14'd0;
            endcase
            return p;
        end
    endfunction

    // Tens and ones of a value below 100; x*205 >> 11 is x/10 over this range.
    function automatic logic [7:0] split99(input logic [6:0] x);
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        begin
            prod = 16'(x) * 16'd205;
            tens = prod[14:11];
            ones = 7'(x - {tens, 3'b000} - {2'b00, tens, 1'b0});
            return {tens, ones[3:0]};
        end
    endfunction

    // Stage B: validity, digit-count flags and the product for the division by 100.
    logic               b_valid_reg;
    ssdc_req_t          b_req_reg;
    logic [VALUE_W-1:0] b_value_reg;
    logic [26:0]        b_prod_reg;
    logic               b_ok_reg;
    logic [NUM_DIGITS-1:1] b_big_reg;

    logic [2:0]            len;
    logic                  field_ok;
    logic                  point_ok;
    logic                  fits;
    logic [NUM_DIGITS-1:1] big;

    always_comb
    begin
        field_ok = ({1'b0, in_req.end_pos} <= DIGIT_COUNT_4)
                && ({1'b0, in_req.first_pos} < in_req.end_pos);
        len      = 3'(in_req.end_pos - {1'b0, in_req.first_pos});
        point_ok = in_req.point_pos <= len;
        fits     = (len > 3'd4) || (in_value < pow10(len));
        for (int j = 1; j < NUM_DIGITS; j++)
        begin
            big[j] = in_value >= pow10(3'(j));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_req_reg   <= in_req;
            b_value_reg <= in_value;
            b_prod_reg  <= 27'(in_value) * 27'd5243;
            b_ok_reg    <= field_ok && point_ok && fits;
            b_big_reg   <= big;
        end
    end

    // Stage C: quotient and remainder by 100.
    logic               c_valid_reg;
    ssdc_req_t          c_req_reg;
    logic               c_ok_reg;
    logic [NUM_DIGITS-1:1] c_big_reg;
    logic [7:0]         c_q_reg;
    logic [6:0]         c_r_reg;

    logic [7:0]         quo;
    logic [VALUE_W-1:0] hundreds;

    always_comb
    begin
        quo      = b_prod_reg[26:19];
        hundreds = 14'({quo, 6'b0}) + 14'({quo, 5'b0}) + 14'({quo, 2'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_req_reg <= b_req_reg;
            c_ok_reg  <= b_ok_reg;
            c_big_reg <= b_big_reg;
            c_q_reg   <= quo;
            c_r_reg   <= 7'(b_value_reg - hundreds);
        end
    end

    // Stage D: five decimal digits.
    logic       d_valid_reg;
    ssdc_req_t  d_req_reg;
    ssdc_num_t  d_num_reg;

    logic       q_hi;
    logic [6:0] q_lo;
    logic [7:0] hi_pair;
    logic [7:0] lo_pair;
    ssdc_num_t  num;

    always_comb
    begin
        q_hi    = c_q_reg >= 8'd100;
        q_lo    = 7'(c_q_reg - (q_hi ? 8'd100 : 8'd0));
        hi_pair = split99(q_lo);
        lo_pair = split99(c_r_reg);
        num.ok       = c_ok_reg;
        num.big      = c_big_reg;
        num.digit[0] = lo_pair[3:0];
        num.digit[1] = lo_pair[7:4];
        num.digit[2] = hi_pair[3:0];
        num.digit[3] = hi_pair[7:4];
        num.digit[4] = {3'b000, q_hi};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_req_reg <= c_req_reg;
            d_num_reg <= num;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_req   = d_req_reg;
    assign out_num   = d_num_reg;

endmodule

// ----- src/ssdc_exec.sv -----
// Execute stage: digit buffer, scan index, colon level and the result register.
// Depends on ssdc_pkg; takes requests already checked and split by ssdc_split.
`timescale 1ns / 1ps

module ssdc_exec #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ssdc_pkg::ssdc_req_t in_req,
    input  ssdc_pkg::ssdc_num_t in_num,
    output logic                out_valid,
    output ssdc_pkg::ssdc_res_t out_res
);
    import ssdc_pkg::*;

    localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    // Segment font for 0..9, segment a in bit 0.
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        begin
            unique case (d)
                4'd0:    g = 8'h3F;
                4'd1:    g = 8'h06;
                4'd2:    g = 8'h5B;
                4'd3:    g = 8'h4F;
                4'd4:    g = 8'h66;
                4'd5:    g = 8'h6D;
                4'd6:    g = 8'h7D;
                4'd7:    g = 8'h07;
                4'd8:    g = 8'h7F;
                4'd9:    g = 8'h6F;
                default: g = 8'h00;
            endcase
            return g;
        end
    endfunction

    logic [7:0]       digit_buffer_reg [DIGIT_COUNT];
    logic [IDX_W-1:0] scan_index_reg;
    logic [IDX_W-1:0] scan_index_next;
    logic             colon_level_reg;
    logic             out_valid_reg;
    ssdc_res_t        res_reg;
    ssdc_res_t        res_next;

    logic [7:0]       pattern [DIGIT_COUNT];
    logic             write_en [DIGIT_COUNT];
    logic             fire;

    assign fire = en && in_valid;

    // New pattern for every position of the write field.
    always_comb
    begin
        for (int p = 0; p < DIGIT_COUNT; p++)
        begin
            logic [3:0] pos;
            logic [3:0] rank;
            logic       in_field;
            logic       show;
            logic [3:0] dval;
            logic       dot;
            pos      = 4'(p);
            rank     = 4'(in_req.end_pos) - 4'd1 - pos;
            in_field = (pos >= 4'(in_req.first_pos)) && (pos < 4'(in_req.end_pos));
            show     = (rank == 4'd0)
                    || ((rank == 4'd1) && in_num.big[1])
                    || ((rank == 4'd2) && in_num.big[2])
                    || ((rank == 4'd3) && in_num.big[3])
                    || ((rank == 4'd4) && in_num.big[4]);
            dval     = (rank <= 4'd4) ? in_num.digit[rank[2:0]] : 4'd0;
            dot      = (in_req.point_pos != 3'd0)
                    && (pos == 4'(in_req.first_pos) + 4'(in_req.point_pos) - 4'd1);
            pattern[p]  = (show ? glyph(dval) : (in_req.fill_zero ? glyph(4'd0) : 8'h00))
                        | (dot ? POINT_BIT : 8'h00);
            write_en[p] = fire && (in_req.cmd == CMD_NUMBER) && in_num.ok && in_field;
        end
    end

    // Result of the request and the next scan index.
    always_comb
    begin
        scan_index_next       = (scan_index_reg == LAST_IDX) ? '0 : scan_index_reg + 1'b1;
        res_next.digit_select = 4'd0;
        res_next.segments_n   = 8'hFF;
        res_next.colon_out    = colon_level_reg;
        res_next.rejected     = 1'b0;
        unique case (in_req.cmd)
            CMD_NUMBER:
            begin
                res_next.rejected = !in_num.ok;
            end
            CMD_SCAN:
            begin
                // Select bits past the fourth digit fall off the shift.
                res_next.digit_select = 4'b0001 << scan_index_reg;
                res_next.segments_n   = ~digit_buffer_reg[scan_index_reg];
            end
            CMD_BLANK:
            begin
                res_next.colon_out = 1'b0;
            end
            CMD_COLON:
            begin
                res_next.colon_out = in_req.colon_on;
            end
            default:
            begin
                res_next.rejected = 1'b0;
            end
        endcase
    end

    // Display state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < DIGIT_COUNT; p++)
            begin
                digit_buffer_reg[p] <= 8'h00;
            end
            scan_index_reg  <= '0;
            colon_level_reg <= 1'b0;
        end
        else
        begin
            for (int p = 0; p < DIGIT_COUNT; p++)
            begin
                if (write_en[p])
                begin
                    digit_buffer_reg[p] <= pattern[p];
                end
            end
            if (fire && (in_req.cmd == CMD_SCAN))
            begin
                scan_index_reg <= scan_index_next;
            end
            if (fire && (in_req.cmd == CMD_COLON))
            begin
                colon_level_reg <= in_req.colon_on;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- src/seven_segment_display_controller_unit.sv -----
// Top level of the seven-segment display controller: input register, pipeline control, ports.
// Depends on ssdc_pkg, ssdc_split and ssdc_exec.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: cmd; tdata: first_pos, end_pos, value, point_pos,
//                        fill_zero, colon_on
//   m_axis    out        tdata: digit_select, segments_n, colon_out, rejected
//
// One request is taken per cycle unless a result waits on m_axis; each result passes through the
// input register, multiply, divide-by-100 stage, digit stage and result register.
// All state changes happen in the execute stage, so requests take effect in order.
// Reset clears the digit buffer to blank digits, the scan index and the colon level.
// While a result waits on m_axis, the whole pipeline holds and s_axis_tready is low.
`timescale 1ns / 1ps

module seven_segment_display_controller_unit #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] first_pos, [4:2] end_pos, [18:5] value, [21:19] point_pos,
    // [22] fill_zero, [23] colon_on
    input  logic [23:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] digit_select, [11:4] segments_n, [12] colon_out, [13] rejected, [15:14] zero
    output logic [15:0] m_axis_tdata
);
    import ssdc_pkg::*;

    logic               en;
    logic               a_valid_reg;
    ssdc_req_t          a_req_reg;
    logic [VALUE_W-1:0] a_value_reg;
    ssdc_req_t          in_req;

    logic               d_valid;
    ssdc_req_t          d_req;
    ssdc_num_t          d_num;
    logic               res_valid;
    ssdc_res_t          res;

    // The pipeline moves whenever the result register is free or being emptied.
    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        in_req.cmd       = s_axis_tuser;
        in_req.first_pos = s_axis_tdata[1:0];
        in_req.end_pos   = s_axis_tdata[4:2];
        in_req.point_pos = s_axis_tdata[21:19];
        in_req.fill_zero = s_axis_tdata[22];
        in_req.colon_on  = s_axis_tdata[23];
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s_axis_tvalid)
        begin
            a_req_reg   <= in_req;
            a_value_reg <= s_axis_tdata[18:5];
        end
    end

    ssdc_split #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_req    (a_req_reg),
        .in_value  (a_value_reg),
        .out_valid (d_valid),
        .out_req   (d_req),
        .out_num   (d_num)
    );

    ssdc_exec #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_req    (d_req),
        .in_num    (d_num),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // Output packing.
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {2'b00, res.rejected, res.colon_out, res.segments_n,
                            res.digit_select};

endmodule

// ----- src/ssdc_checker.sv -----
// Port-level checks for the seven-segment display controller, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module ssdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A stalled result stalls the whole pipeline, so no request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    // At most one digit is driven at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
        else $error("more than one digit selected");

    // A rejected write drives no digit and leaves every segment dark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |->
            (m_axis_tdata[3:0] == 4'd0) && (m_axis_tdata[11:4] == 8'hFF))
        else $error("rejected result drives the display");

    // No result is offered right out of reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind seven_segment_display_controller_unit ssdc_checker u_ssdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/ssdc_display_checker.sv -----
// Checker for the seven-segment display controller: watches both stream channels,
// predicts each result from its own copy of the display state and compares.
// Depends on ssdc_pkg for the command codes, the point bit and the result layout.
`timescale 1ns / 1ps

module ssdc_display_checker #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [1:0] first_pos, [4:2] end_pos, [18:5] value, [21:19] point_pos,
    // [22] fill_zero, [23] colon_on
    input  logic [23:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] digit_select, [11:4] segments_n, [12] colon_out, [13] rejected, [15:14] zero
    input  logic [15:0] m_axis_tdata,
    output int unsigned fail_count,
    output int unsigned pending
);
    import ssdc_pkg::*;

    // Predicted display state: one glyph per digit, the scan position and the colon.
    logic [7:0]  shown_glyphs [DIGIT_COUNT];
    int unsigned scan_pos;
    logic        colon_lvl;

    // Results still owed by the block, oldest first.
    ssdc_res_t   expected_results [$];

    // Segment font for one decimal digit, decimal point off.
    function automatic logic [7:0] glyph_of(input int unsigned d);
        case (d)
            0:       glyph_of = 8'h3F;
            1:       glyph_of = 8'h06;
            2:       glyph_of = 8'h5B;
            3:       glyph_of = 8'h4F;
            4:       glyph_of = 8'h66;
            5:       glyph_of = 8'h6D;
            6:       glyph_of = 8'h7D;
            7:       glyph_of = 8'h07;
            8:       glyph_of = 8'h7F;
            default: glyph_of = 8'h6F;
        endcase
    endfunction

    // Applies one request to the predicted state and works out its result.
    task automatic predict_display(input ssdc_req_t req, input logic [VALUE_W-1:0] value,
                                   output ssdc_res_t res);
        int unsigned first;
        int unsigned stop;
        int unsigned span;
        int unsigned limit;
        int unsigned pos;
        int unsigned v;
        int unsigned k;
        res.digit_select = 4'h0;
        res.segments_n   = 8'hFF;
        res.colon_out    = colon_lvl;
        res.rejected     = 1'b0;
        case (req.cmd)
            CMD_NUMBER:
            begin
                first = req.first_pos;
                stop  = req.end_pos;
                v     = value;
                span  = (stop > first) ? stop - first : 0;
                limit = 1;
                for (k = 0; k < span; k++)
                    limit = limit * 10;
                // A bad field, a point outside the field or a value that does not fit
                // leaves the display untouched.
                if (stop > DIGIT_COUNT || span == 0 || req.point_pos > span || v >= limit)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    pos = stop;
                    do
                    begin
                        pos = pos - 1;
                        shown_glyphs[pos] = glyph_of(v % 10);
                        v = v / 10;
                    end while (v != 0 && pos > first);
                    while (pos > first)
                    begin
                        pos = pos - 1;
                        shown_glyphs[pos] = req.fill_zero ? glyph_of(0) : 8'h00;
                    end
                    if (req.point_pos != 0)
                        shown_glyphs[first + req.point_pos - 1] |= POINT_BIT;
                end
            end
            CMD_SCAN:
            begin
                res.digit_select = (scan_pos < 4) ? 4'(1 << scan_pos) : 4'h0;
                res.segments_n   = ~shown_glyphs[scan_pos];
                scan_pos         = (scan_pos + 1) % DIGIT_COUNT;
            end
            CMD_BLANK:
            begin
                res.colon_out = 1'b0;
            end
            default:
            begin
                colon_lvl     = req.colon_on;
                res.colon_out = colon_lvl;
            end
        endcase
    endtask

    // Counts and reports one failure.
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count = fail_count + 1;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Results are checked before requests are predicted, so a result can never be
    // matched against a request taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        ssdc_req_t req;
        ssdc_res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                shown_glyphs[i] = 8'h00;
            scan_pos  = 0;
            colon_lvl = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t ns: result with no request pending, %s 0x%0h",
                             $time, "expected none, actual", m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("digit_select", want.digit_select, m_axis_tdata[3:0]);
                    check_field("segments_n", want.segments_n, m_axis_tdata[11:4]);
                    check_field("colon_out", want.colon_out, m_axis_tdata[12]);
                    check_field("rejected", want.rejected, m_axis_tdata[13]);
                    check_field("tdata padding", 0, m_axis_tdata[15:14]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                req.cmd       = s_axis_tuser;
                req.first_pos = s_axis_tdata[1:0];
                req.end_pos   = s_axis_tdata[4:2];
                req.point_pos = s_axis_tdata[21:19];
                req.fill_zero = s_axis_tdata[22];
                req.colon_on  = s_axis_tdata[23];
                predict_display(req, s_axis_tdata[18:5], want);
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

// ----- tb/tb_seven_segment_display_controller_unit.sv -----
// Testbench top for the seven-segment display controller: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on ssdc_pkg, the block under test and ssdc_display_checker.
`timescale 1ns / 1ps

module tb_seven_segment_display_controller_unit;
    import ssdc_pkg::*;

    localparam int unsigned DIGIT_COUNT  = 4;
    localparam int unsigned ITEM_COUNT   = 800;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 12;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = CMD_SCAN;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned idle_cycles = 0;
    int unsigned tick_count  = 0;
    int unsigned burst_left  = 0;

    always #5 clk = ~clk;

    seven_segment_display_controller_unit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    ssdc_display_checker #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Result back-pressure: always ready, coin-flip, mostly stalled and a fixed
    // pattern, taken in turn as bits 9:8 of tick_count step.
    always @(negedge clk)
    begin
        tick_count <= tick_count + 1;
        case ((tick_count >> 8) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((tick_count % 7) < 3);
        endcase
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Presents one request and holds it until it is taken; requests go out in bursts
    // of random length with random gaps, some bursts running back to back.
    task automatic send_request(input logic [1:0] cmd, input logic [1:0] first,
                                input logic [2:0] stop, input logic [13:0] value,
                                input logic [2:0] point, input logic fill,
                                input logic colon);
        int unsigned gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {colon, fill, point, value, stop, first};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Number write with a random colon bit riding along.
    task automatic write_value(input int unsigned first, input int unsigned stop,
                               input int unsigned value, input int unsigned point,
                               input logic fill);
        send_request(CMD_NUMBER, first[1:0], stop[2:0], value[13:0], point[2:0], fill,
                     1'($urandom_range(0, 1)));
    endtask

    // Scan, blank or colon request; the fields it ignores carry random bits.
    task automatic send_op(input logic [1:0] cmd, input logic colon);
        send_request(cmd, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     14'($urandom_range(0, 16383)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), colon);
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned first;
        int unsigned stop;
        int unsigned span;
        int unsigned value;
        int unsigned point;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Blank display straight after reset.
        repeat (4) send_op(CMD_SCAN, 1'b0);
        // Full field at its largest value, then a zero value with zero fill and blank fill.
        write_value(0, 4, 9999, 0, 1'b0);
        write_value(0, 4, 0, 4, 1'b1);
        write_value(0, 4, 0, 1, 1'b0);
        write_value(1, 3, 12, 1, 1'b0);
        write_value(3, 4, 7, 1, 1'b1);
        write_value(0, 4, 5, 2, 1'b1);
        // Rejected writes: point outside the field, bad fields, values that do not fit.
        write_value(2, 4, 3, 3, 1'b0);
        write_value(0, 3, 1, 7, 1'b0);
        write_value(1, 5, 1, 0, 1'b0);
        write_value(0, 7, 1, 0, 1'b1);
        write_value(3, 3, 1, 0, 1'b0);
        write_value(2, 1, 1, 0, 1'b0);
        write_value(0, 0, 0, 0, 1'b0);
        write_value(2, 4, 100, 0, 1'b0);
        write_value(0, 4, 16383, 0, 1'b1);
        // Colon on and off, with a blank in between.
        send_op(CMD_COLON, 1'b1);
        send_op(CMD_BLANK, 1'b0);
        send_op(CMD_SCAN, 1'b0);
        send_op(CMD_COLON, 1'b0);
        repeat (4) send_op(CMD_SCAN, 1'b1);

        // Random part: mostly well-formed number writes and scans, some raw noise.
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                first = $urandom_range(0, 3);
                stop  = $urandom_range(first + 1, 4);
                span  = stop - first;
                case ($urandom_range(0, 7))
                    0:       value = $urandom_range(0, 9);
                    1:       value = 10 ** span - 1;
                    2:       value = 10 ** span;
                    default: value = $urandom_range(0, 10 ** span - 1);
                endcase
                point = ($urandom_range(0, 9) == 0) ? span + 1 : $urandom_range(0, span);
                write_value(first, stop, value, point, 1'($urandom_range(0, 1)));
            end
            else if (pick < 45)
            begin
                send_request(CMD_NUMBER, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             14'($urandom_range(0, 16383)), 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 80)
            begin
                send_op(CMD_SCAN, 1'($urandom_range(0, 1)));
            end
            else if (pick < 88)
            begin
                send_op(CMD_BLANK, 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_op(CMD_COLON, 1'($urandom_range(0, 1)));
            end
        end

        // Drain the pipeline, then give a stray result time to show up.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ssdc_pkg.sv
src/ssdc_split.sv
src/ssdc_exec.sv
src/seven_segment_display_controller_unit.sv
src/ssdc_checker.sv
tb/ssdc_display_checker.sv
tb/tb_seven_segment_display_controller_unit.sv
